### hdl/pslp_pkg.sv
// types and constants for the straight-line photon pusher
// no dependencies; imported by photon_straight_line_push
package pslp_pkg;

	localparam int MOM_W      = 24;
	localparam int POS_W      = 32;
	localparam int DT_W       = 16;
	localparam int INV_W      = 32;
	localparam int SUM_W      = 48;
	localparam int QUO_W      = 64;
	localparam int DIV_STEPS  = 80;
	localparam int SQRT_STEPS = 32;
	localparam int SQRT_REM_W = 34;
	localparam int P1_W       = 41;
	localparam int P2_W       = 57;
	localparam int ROUND_SH   = 36;
	localparam int STEP_W     = 21;

	localparam logic [DT_W-1:0]  TIME_STEP_RESET = 16'd4096;
	localparam logic [INV_W-1:0] INV_MAX         = '1;
	localparam logic [SUM_W-1:0] SMALL_LIMIT     = 48'd65536;

	// per-item data carried alongside the arithmetic
	typedef struct packed {
		logic [2:0][MOM_W-1:0] mag;
		logic [2:0]            neg;
		logic [2:0][POS_W-1:0] pos;
		logic                  last;
		logic                  zero;
		logic                  tiny;
	} side_t;

endpackage

### hdl/photon_straight_line_push.sv
// straight-line photon pusher, fully pipelined top level
// depends on pslp_pkg
//
// Usage: one particle per item on the slave stream. s_axis_tdata carries
// the three momentum components (signed Q7.16) and three positions
// (signed Q16.16); s_axis_tlast marks the last particle of a batch.
// The master stream returns the new positions and the inverse momentum
// magnitude (unsigned Q8.24) in m_axis_tdata, the zero-momentum flag in
// m_axis_tuser and the batch mark in m_axis_tlast.
// The time step (unsigned Q4.12) is written through cfg_we / cfg_wdata
// while the block is empty; reset loads 1.0.
// Throughput: one item per cycle while the receiver keeps up. The path
// has 117 register stages: the 80 restoring division stages for 2^80/S
// and the 32 square-root stages, plus two stages for the sum of squares
// and three for the step multiply, rounding and saturating add.
// Reset clears all valid bits and loads the time step with 1.0. When the
// receiver stalls the whole pipeline holds; s_axis_tready falls while the
// output register holds an item that is not taken.
module photon_straight_line_push (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,      // time_step
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [167:0] s_axis_tdata,   // mom_x, mom_y, mom_z, pos_x, pos_y, pos_z
	input  logic         s_axis_tlast,   // is_last_in
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,   // new_pos_x, new_pos_y, new_pos_z, inv_norm
	output logic         m_axis_tuser,   // zero_momentum
	output logic         m_axis_tlast    // is_last_out
);
	import pslp_pkg::*;

	logic en;
	logic [DT_W-1:0] time_step_q;

	// stage 1 and 2
	logic                       vld_s1, vld_s2;
	side_t                      side_s1, side_s2;
	logic [2:0][SUM_W-1:0]      sq_s1;
	logic [SUM_W-1:0]           sum_s2;

	// division and square root stages, index 0 is the feeding stage
	logic [DIV_STEPS:0]         div_vld_s;
	side_t                      div_side_s [DIV_STEPS+1];
	logic [SUM_W-1:0]           div_rem_s  [DIV_STEPS+1];
	logic [SUM_W-1:0]           div_den_s  [DIV_STEPS+1];
	logic [QUO_W-1:0]           div_quo_s  [DIV_STEPS+1];

	logic [SQRT_STEPS:0]        sq_vld_s;
	side_t                      sq_side_s  [SQRT_STEPS+1];
	logic [QUO_W-1:0]           sq_rad_s   [SQRT_STEPS+1];
	logic [SQRT_REM_W-1:0]      sq_rem_s   [SQRT_STEPS+1];
	logic [INV_W-1:0]           sq_root_s  [SQRT_STEPS+1];

	// step multiply and output stages
	logic                       vld_m1, vld_m2, vld_m3;
	side_t                      side_m1, side_m2;
	logic [INV_W-1:0]           inv_m1, inv_m2, inv_m3;
	logic [2:0][P1_W-1:0]       p1_m1;
	logic [2:0][P2_W-1:0]       p2_m2;
	logic [2:0][POS_W-1:0]      npos_m3;
	logic                       zero_m3, last_m3;

	// the pipeline moves whenever the output register can take an item
	assign en = !vld_m3 || m_axis_tready;
	assign s_axis_tready = en;

	// time step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= TIME_STEP_RESET;
		end else if (cfg_we) begin
			time_step_q <= cfg_wdata;
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			div_vld_s[DIV_STEPS:1] <= '0;
			sq_vld_s[SQRT_STEPS:1] <= '0;
			vld_m1    <= 1'b0;
			vld_m2    <= 1'b0;
			vld_m3    <= 1'b0;
		end else if (en) begin
			vld_s1    <= s_axis_tvalid;
			vld_s2    <= vld_s1;
			div_vld_s[DIV_STEPS:1] <= div_vld_s[DIV_STEPS-1:0];
			sq_vld_s[SQRT_STEPS:1] <= sq_vld_s[SQRT_STEPS-1:0];
			vld_m1    <= sq_vld_s[SQRT_STEPS];
			vld_m2    <= vld_m1;
			vld_m3    <= vld_m2;
		end
	end

	assign div_vld_s[0] = vld_s2;
	assign sq_vld_s[0]  = div_vld_s[DIV_STEPS];

	// stage 1: magnitudes, signs and squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [MOM_W-1:0] m;
				logic signed [SUM_W-1:0] mw;
				m  = s_axis_tdata[i*MOM_W +: MOM_W];
				mw = SUM_W'(m);
				side_s1.neg[i] <= m[MOM_W-1];
				side_s1.mag[i] <= m[MOM_W-1] ? MOM_W'(-m) : MOM_W'(m);
				sq_s1[i]       <= mw * mw;
				side_s1.pos[i] <= s_axis_tdata[3*MOM_W + i*POS_W +: POS_W];
			end
			side_s1.last <= s_axis_tlast;
			side_s1.zero <= 1'b0;
			side_s1.tiny <= 1'b0;
		end
	end

	// stage 2: sum of squares and special cases
	always_ff @(posedge clk) begin
		if (en) begin
			logic [SUM_W-1:0] s;
			side_t            sd;
			s       = sq_s1[0] + sq_s1[1] + sq_s1[2];
			sd      = side_s1;
			sd.zero = (s == '0);
			sd.tiny = (s <= SMALL_LIMIT);
			sum_s2  <= s;
			side_s2 <= sd;
		end
	end

	// the first step of 2^80/S leaves a remainder of one
	assign div_side_s[0] = side_s2;
	assign div_rem_s[0]  = SUM_W'(1);
	assign div_den_s[0]  = sum_s2;
	assign div_quo_s[0]  = '0;

	// restoring division, one quotient bit per stage
	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
		logic [SUM_W:0] sh;
		logic           ge;
		assign sh = {div_rem_s[k-1], 1'b0};
		assign ge = sh >= {1'b0, div_den_s[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				div_side_s[k] <= div_side_s[k-1];
				div_den_s[k]  <= div_den_s[k-1];
				div_rem_s[k]  <= ge ? SUM_W'(sh - {1'b0, div_den_s[k-1]}) : SUM_W'(sh);
				div_quo_s[k]  <= {div_quo_s[k-1][QUO_W-2:0], ge};
			end
		end
	end

	assign sq_side_s[0] = div_side_s[DIV_STEPS];
	assign sq_rad_s[0]  = div_quo_s[DIV_STEPS];
	assign sq_rem_s[0]  = '0;
	assign sq_root_s[0] = '0;

	// digit-by-digit square root, one root bit per stage
	for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
		logic [SQRT_REM_W+1:0] rs;
		logic [SQRT_REM_W+1:0] trial;
		logic                  ge;
		assign rs    = {sq_rem_s[k-1], sq_rad_s[k-1][QUO_W-1:QUO_W-2]};
		assign trial = {2'b00, sq_root_s[k-1], 2'b01};
		assign ge    = rs >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				sq_side_s[k] <= sq_side_s[k-1];
				sq_rad_s[k]  <= {sq_rad_s[k-1][QUO_W-3:0], 2'b00};
				sq_rem_s[k]  <= ge ? SQRT_REM_W'(rs - trial) : SQRT_REM_W'(rs);
				sq_root_s[k] <= {sq_root_s[k-1][INV_W-2:0], ge};
			end
		end
	end

	// m1: magnitude times inverse norm
	always_ff @(posedge clk) begin
		if (en) begin
			logic [INV_W-1:0] inv;
			inv = sq_side_s[SQRT_STEPS].tiny ? INV_MAX : sq_root_s[SQRT_STEPS];
			inv_m1  <= inv;
			side_m1 <= sq_side_s[SQRT_STEPS];
			for (int i = 0; i < 3; i++) begin
				p1_m1[i] <= P1_W'(sq_side_s[SQRT_STEPS].mag[i]) * P1_W'(inv);
			end
		end
	end

	// m2: times the time step
	always_ff @(posedge clk) begin
		if (en) begin
			inv_m2  <= inv_m1;
			side_m2 <= side_m1;
			for (int i = 0; i < 3; i++) begin
				p2_m2[i] <= P2_W'(p1_m1[i]) * P2_W'(time_step_q);
			end
		end
	end

	// m3: round, apply sign, saturating add
	always_ff @(posedge clk) begin
		if (en) begin
			inv_m3  <= inv_m2;
			zero_m3 <= side_m2.zero;
			last_m3 <= side_m2.last;
			for (int i = 0; i < 3; i++) begin
				logic [P2_W-1:0]         rnd;
				logic [STEP_W-1:0]       d;
				logic signed [POS_W+1:0] sum;
				rnd = p2_m2[i] + (P2_W'(1) << (ROUND_SH - 1));
				d   = rnd[ROUND_SH +: STEP_W];
				sum = $signed({{2{side_m2.pos[i][POS_W-1]}}, side_m2.pos[i]});
				if (side_m2.neg[i])
					sum = sum - $signed({{(POS_W+2-STEP_W){1'b0}}, d});
				else
					sum = sum + $signed({{(POS_W+2-STEP_W){1'b0}}, d});
				if (sum > $signed({2'b00, 1'b0, {(POS_W-1){1'b1}}}))
					npos_m3[i] <= {1'b0, {(POS_W-1){1'b1}}};
				else if (sum < $signed({2'b11, 1'b1, {(POS_W-1){1'b0}}}))
					npos_m3[i] <= {1'b1, {(POS_W-1){1'b0}}};
				else
					npos_m3[i] <= sum[POS_W-1:0];
			end
		end
	end

	// output stream
	assign m_axis_tvalid = vld_m3;
	assign m_axis_tdata  = {inv_m3, npos_m3[2], npos_m3[1], npos_m3[0]};
	assign m_axis_tuser  = zero_m3;
	assign m_axis_tlast  = last_m3;

	// checks
	a_zero_inv: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[127:96] == INV_MAX)
		else $error("zero momentum without saturated inverse");

	a_zero_tiny: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && side_s2.zero |-> side_s2.tiny)
		else $error("zero sum not flagged as tiny");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |=> $stable(vld_m1) && $stable(inv_m2))
		else $error("pipeline moved during stall");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("ready does not follow output stall");

endmodule
